// ===== design/c3as_pkg.sv =====
// ----------------------------------------------------------------------------
// c3as_pkg
// Shared types and constants of the 3x3 convolution block: register codes,
// reset values, pixel column and coefficient column types.
// ----------------------------------------------------------------------------
package c3as_pkg;

	localparam int PIX_W        = 8;
	localparam int COEF_W       = 8;
	localparam int WIDTH_REG_W  = 10;
	localparam int HEIGHT_REG_W = 16;
	localparam int COEF_ROW_W   = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 24;
	// one product: 9-bit unsigned pixel times 8-bit signed coefficient
	localparam int PROD_W       = PIX_W + 1 + COEF_W;
	// three products of one column
	localparam int PSUM_W       = PROD_W + 2;
	// three columns
	localparam int SUM_W        = PSUM_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_COEF_TOP     = 3'd2,
		REG_COEF_MID     = 3'd3,
		REG_COEF_BOT     = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		REQ_PIXEL = 1'b0,
		REQ_FLUSH = 1'b1
	} req_type_t;

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET    = 10'd512;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET   = 16'd512;
	localparam logic [COEF_ROW_W-1:0]   COEF_TOP_RESET = 24'h000000;
	localparam logic [COEF_ROW_W-1:0]   COEF_MID_RESET = 24'h000100;
	localparam logic [COEF_ROW_W-1:0]   COEF_BOT_RESET = 24'h000000;
	localparam logic [PIX_W-1:0]        PIX_MAX        = 8'd255;

	typedef logic [PIX_W-1:0] pix_t;

	// one window column, top to bottom
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} pix_col_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] top;
		logic signed [COEF_W-1:0] mid;
		logic signed [COEF_W-1:0] bot;
	} coef_col_t;

	// entry of the line store: two rows above the current one
	typedef struct packed {
		pix_t upper;
		pix_t lower;
	} line_pair_t;

	// padding of the window held in the first pipeline stage
	typedef struct packed {
		logic top_en;
		logic bot_en;
		logic left_en;
		logic right_en;
	} tap_mask_t;

	// per-cell enables for zero padding
	typedef struct packed {
		logic top_en;
		logic bot_en;
		logic col_en;
	} cell_ctrl_t;

endpackage

// ===== design/conv3x3_abs_saturate.sv =====
// ----------------------------------------------------------------------------
// conv3x3_abs_saturate
// Streaming 3x3 convolution of 8-bit pixels, |sum| saturated to 255.
// Throughput: one item per clock while the output is not stalled; the line
// store read for the next column is prefetched so its single read port keeps
// pace with the input. A result passes stage 1, stage 2 and the output register;
// output k is completed by input item k + width + 1 (flush items drain the end).
// Reset clears counters, window and valids; the line store is not cleared.
// ----------------------------------------------------------------------------
module conv3x3_abs_saturate #(
	parameter int MAX_WIDTH = 512
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [c3as_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [c3as_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                req_type,
	input  logic [c3as_pkg::PIX_W-1:0]          pixel_in,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [c3as_pkg::PIX_W-1:0]          pixel_out,
	output logic                                frame_last
);
	import c3as_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CW    = (WW > WIDTH_REG_W) ? WW : WIDTH_REG_W;

	// configuration
	logic [WIDTH_REG_W-1:0]   image_width_q;
	logic [HEIGHT_REG_W-1:0]  image_height_q;
	logic [COEF_ROW_W-1:0]    coef_top_q;
	logic [COEF_ROW_W-1:0]    coef_mid_q;
	logic [COEF_ROW_W-1:0]    coef_bot_q;

	// position counters
	logic [COL_W-1:0]         in_col_q;
	logic [HEIGHT_REG_W-1:0]  in_row_q;
	logic [COL_W-1:0]         out_col_q;
	logic [HEIGHT_REG_W-1:0]  out_row_q;
	logic [COL_W-1:0]         in_col_d;
	logic [HEIGHT_REG_W-1:0]  in_row_d;
	logic [COL_W-1:0]         out_col_d;
	logic [HEIGHT_REG_W-1:0]  out_row_d;

	logic [WW-1:0]            w_eff;
	logic [HEIGHT_REG_W-1:0]  h_eff;
	logic                     in_col_last;
	logic                     out_col_last;
	logic                     out_row_last;
	logic                     emit;
	logic                     last_now;

	// handshake and pipeline
	logic                     en_a;
	logic                     en_b;
	logic                     en_out;
	logic                     go;
	logic                     valid_s1;
	logic                     valid_s2;
	logic                     out_valid_q;
	tap_mask_t                mask_s1;
	logic                     last_s1;
	logic                     last_s2;

	pix_t                     pix;
	line_pair_t               lb_rd;
	line_pair_t               lb_wr;
	logic [COL_W-1:0]         lb_rd_addr;
	pix_col_t                 new_col;
	pix_col_t                 col_right;
	pix_col_t                 col_mid;
	coef_col_t                coef_left;
	coef_col_t                coef_mid;
	coef_col_t                coef_right;
	cell_ctrl_t               ctrl_left;
	cell_ctrl_t               ctrl_mid;
	cell_ctrl_t               ctrl_right;
	logic signed [PSUM_W-1:0] psum_left;
	logic signed [PSUM_W-1:0] psum_mid;
	logic signed [PSUM_W-1:0] psum_right;
	logic signed [SUM_W-1:0]  sum;
	logic [SUM_W-1:0]         mag;
	pix_t                     sat;
	pix_t                     pix_out_q;
	logic                     last_q;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
			coef_top_q     <= COEF_TOP_RESET;
			coef_mid_q     <= COEF_MID_RESET;
			coef_bot_q     <= COEF_BOT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_REG_W-1:0];
				REG_COEF_TOP:     coef_top_q     <= cfg_data[COEF_ROW_W-1:0];
				REG_COEF_MID:     coef_mid_q     <= cfg_data[COEF_ROW_W-1:0];
				REG_COEF_BOT:     coef_bot_q     <= cfg_data[COEF_ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size: width clamped to 1..MAX_WIDTH, height at least 1
	always_comb begin
		if (image_width_q == '0) begin
			w_eff = WW'(1);
		end else if (CW'(image_width_q) > CW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(image_width_q);
		end
		h_eff = (image_height_q == '0) ? HEIGHT_REG_W'(1) : image_height_q;
	end

	// ------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------
	assign en_out   = !out_valid_q || !out_stall;
	assign en_b     = !valid_s2 || en_out;
	assign en_a     = !valid_s1 || en_b;
	assign in_stall = !en_a;
	assign go       = in_valid && en_a;

	// ------------------------------------------------------------------
	// position tracking
	// ------------------------------------------------------------------
	always_comb begin
		in_col_last  = WW'(in_col_q) >= (w_eff - WW'(1));
		out_col_last = WW'(out_col_q) >= (w_eff - WW'(1));
		out_row_last = out_row_q >= (h_eff - HEIGHT_REG_W'(1));
		emit         = (in_row_q >= HEIGHT_REG_W'(2)) ||
		               ((in_row_q == HEIGHT_REG_W'(1)) && (in_col_q != '0));
		last_now     = out_row_last && out_col_last;

		if (in_col_last) begin
			in_col_d = '0;
			in_row_d = (in_row_q != '1) ? in_row_q + HEIGHT_REG_W'(1) : in_row_q;
		end else begin
			in_col_d = in_col_q + COL_W'(1);
			in_row_d = in_row_q;
		end

		if (!emit) begin
			out_col_d = out_col_q;
			out_row_d = out_row_q;
		end else if (last_now) begin
			// frame end: every counter restarts
			in_col_d  = '0;
			in_row_d  = '0;
			out_col_d = '0;
			out_row_d = '0;
		end else if (out_col_last) begin
			out_col_d = '0;
			out_row_d = (out_row_q != '1) ? out_row_q + HEIGHT_REG_W'(1) : out_row_q;
		end else begin
			out_col_d = out_col_q + COL_W'(1);
			out_row_d = out_row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (go) begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
		end
	end

	// ------------------------------------------------------------------
	// line store: the read port follows the column of the next request
	// ------------------------------------------------------------------
	assign pix        = (req_type == REQ_FLUSH) ? '0 : pixel_in;
	assign lb_wr      = '{upper: lb_rd.lower, lower: pix};
	assign lb_rd_addr = go ? in_col_d : in_col_q;

	c3as_linebuf #(
		.DEPTH(MAX_WIDTH)
	) u_linebuf (
		.clk     (clk),
		.wr_en   (go),
		.wr_addr (in_col_q),
		.wr_data (lb_wr),
		.rd_addr (lb_rd_addr),
		.rd_data (lb_rd)
	);

	// ------------------------------------------------------------------
	// stage 1: window cells, stage 2: column partial sums
	// ------------------------------------------------------------------
	assign new_col = '{top: lb_rd.upper, mid: lb_rd.lower, bot: pix};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_a) begin
			valid_s1 <= go && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			mask_s1.top_en   <= out_row_q != '0;
			mask_s1.bot_en   <= !out_row_last;
			mask_s1.left_en  <= out_col_q != '0;
			mask_s1.right_en <= !out_col_last;
			last_s1          <= last_now;
		end
	end

	assign coef_left  = {coef_top_q[7:0],   coef_mid_q[7:0],   coef_bot_q[7:0]};
	assign coef_mid   = {coef_top_q[15:8],  coef_mid_q[15:8],  coef_bot_q[15:8]};
	assign coef_right = {coef_top_q[23:16], coef_mid_q[23:16], coef_bot_q[23:16]};

	assign ctrl_left  = '{top_en: mask_s1.top_en, bot_en: mask_s1.bot_en,
	                      col_en: mask_s1.left_en};
	assign ctrl_mid   = '{top_en: mask_s1.top_en, bot_en: mask_s1.bot_en,
	                      col_en: 1'b1};
	assign ctrl_right = '{top_en: mask_s1.top_en, bot_en: mask_s1.bot_en,
	                      col_en: mask_s1.right_en};

	c3as_cell u_cell_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (go),
		.col_in   (new_col),
		.col_out  (col_right),
		.load_en  (en_b),
		.coef     (coef_right),
		.ctrl     (ctrl_right),
		.psum     (psum_right)
	);

	c3as_cell u_cell_mid (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (go),
		.col_in   (col_right),
		.col_out  (col_mid),
		.load_en  (en_b),
		.coef     (coef_mid),
		.ctrl     (ctrl_mid),
		.psum     (psum_mid)
	);

	c3as_cell u_cell_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (go),
		.col_in   (col_mid),
		.col_out  (),
		.load_en  (en_b),
		.coef     (coef_left),
		.ctrl     (ctrl_left),
		.psum     (psum_left)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_b) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_b) begin
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// output register: final sum, magnitude, saturation
	// ------------------------------------------------------------------
	always_comb begin
		sum = SUM_W'(psum_left) + SUM_W'(psum_mid) + SUM_W'(psum_right);
		mag = sum[SUM_W-1] ? $unsigned(-sum) : $unsigned(sum);
		sat = (mag > SUM_W'(PIX_MAX)) ? PIX_MAX : mag[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			pix_out_q <= sat;
			last_q    <= last_s2;
		end
	end

	assign out_valid  = out_valid_q;
	assign pixel_out  = pix_out_q;
	assign frame_last = last_q;

endmodule

// ===== design/c3as_linebuf.sv =====
// ----------------------------------------------------------------------------
// c3as_linebuf
// Line store holding the two previous rows per column, one write and one
// registered read per cycle, with write-to-read bypass on the same address.
// ----------------------------------------------------------------------------
module c3as_linebuf #(
	parameter int DEPTH = 512
) (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  c3as_pkg::line_pair_t       wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output c3as_pkg::line_pair_t       rd_data
);
	import c3as_pkg::*;

	line_pair_t mem [DEPTH];
	line_pair_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// a one-pixel-wide row reads back the entry written in the same cycle
	always_ff @(posedge clk) begin
		if (wr_en && (rd_addr == wr_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// ===== design/c3as_cell.sv =====
// ----------------------------------------------------------------------------
// c3as_cell
// One column of the 3x3 window: holds three pixels, passes them to its left
// neighbor on every request, and forms the column's registered partial sum.
// ----------------------------------------------------------------------------
module c3as_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  shift_en,
	input  c3as_pkg::pix_col_t                    col_in,
	output c3as_pkg::pix_col_t                    col_out,
	input  logic                                  load_en,
	input  c3as_pkg::coef_col_t                   coef,
	input  c3as_pkg::cell_ctrl_t                  ctrl,
	output logic signed [c3as_pkg::PSUM_W-1:0]    psum
);
	import c3as_pkg::*;

	pix_col_t                   col_q;
	pix_t                       top_g;
	pix_t                       mid_g;
	pix_t                       bot_g;
	logic signed [PIX_W:0]      top_x;
	logic signed [PIX_W:0]      mid_x;
	logic signed [PIX_W:0]      bot_x;
	logic signed [PROD_W-1:0]   prod_top;
	logic signed [PROD_W-1:0]   prod_mid;
	logic signed [PROD_W-1:0]   prod_bot;
	logic signed [PSUM_W-1:0]   psum_d;
	logic signed [PSUM_W-1:0]   psum_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift_en) begin
			col_q <= col_in;
		end
	end

	// padded taps are forced to zero at the pixel, not the coefficient
	always_comb begin
		top_g = col_q.top & {PIX_W{ctrl.top_en & ctrl.col_en}};
		mid_g = col_q.mid & {PIX_W{ctrl.col_en}};
		bot_g = col_q.bot & {PIX_W{ctrl.bot_en & ctrl.col_en}};
		top_x = {1'b0, top_g};
		mid_x = {1'b0, mid_g};
		bot_x = {1'b0, bot_g};
		prod_top = top_x * coef.top;
		prod_mid = mid_x * coef.mid;
		prod_bot = bot_x * coef.bot;
		psum_d = PSUM_W'(prod_top) + PSUM_W'(prod_mid) + PSUM_W'(prod_bot);
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			psum_s2 <= psum_d;
		end
	end

	assign col_out = col_q;
	assign psum    = psum_s2;

endmodule

// ===== design/c3as_checker.sv =====
// ----------------------------------------------------------------------------
// c3as_checker
// Port-level checks of the convolution block over time, bound to its top.
// ----------------------------------------------------------------------------
module c3as_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] pixel_out,
	input logic       frame_last
);

	logic in_req;

	assign in_req = in_valid && !in_stall;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_out) && $stable(frame_last))
	else $error("stalled result changed");

	// the input side only waits behind a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
	else $error("input stalled while output free");

	// with the output unstalled throughout, a result needs a request that has
	// passed stage 1, stage 2 and the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(out_stall, 1) && !$past(out_stall, 2) && !$past(out_stall, 3) &&
		!$past(in_req, 3) |-> !out_valid)
	else $error("result without a matching request");

endmodule

bind conv3x3_abs_saturate c3as_checker u_checker (.*);
